// File: src/si2d_pkg.sv
// ----------------------------------------------------------------------------
// si2d_pkg: shared types and constants
// Coordinate widths, intermediate product widths, the rejection reasons
// and pipeline latencies of the segment intersection block.
// Coordinates are signed Q15.8; the integer datapath does not depend on
// where the binary point sits.
// ----------------------------------------------------------------------------
package si2d_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int CW          = COORD_WIDTH;
	localparam int DW          = CW + 1;          // coordinate difference
	localparam int PW          = 2 * DW;          // product of two differences
	localparam int XW          = PW + 1;          // cross product
	localparam int LO_W        = XW - DW;         // low slice of a cross product
	localparam int NW          = DW + XW;         // dividend
	localparam int QBITS       = CW + 3;          // quotient magnitude bits
	localparam int QW          = QBITS + 2;       // signed clamped quotient
	localparam int PXW         = QW + 1;          // point before saturation
	localparam int EW          = CW + 3;          // point minus an end of A
	localparam int DIST_WIDTH  = 50;
	localparam int DRW         = DIST_WIDTH / 2;  // root limit of the distance

	localparam int FRONT_LAT   = 3;
	localparam int DIV_LAT     = QBITS + 5;
	localparam int BACK_LAT    = 4;
	localparam int LATENCY     = FRONT_LAT + DIV_LAT + BACK_LAT;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [XW-1:0] cross_t;
	typedef logic signed [QW-1:0] quot_t;

	typedef enum logic [2:0] {
		REASON_HIT       = 3'd0,
		REASON_DEG_A     = 3'd1,
		REASON_DEG_B     = 3'd2,
		REASON_SAME_SIDE = 3'd3,
		REASON_OUTSIDE   = 3'd4
	} reason_t;

	// Per-request data that travels beside the divider
	typedef struct packed {
		logic    mode;
		reason_t reason;
		coord_t  base_x;
		coord_t  base_z;
		coord_t  a1_x;
		coord_t  a1_z;
		coord_t  a2_x;
		coord_t  a2_z;
		coord_t  b1_x;
		coord_t  b1_z;
	} side_t;

	function automatic diff_t coord_diff(coord_t a, coord_t b);
		return DW'(a) - DW'(b);
	endfunction

	function automatic cross_t cross_diff(prod_t a, prod_t b);
		return XW'(a) - XW'(b);
	endfunction

	function automatic logic [DW-1:0] diff_abs(diff_t a);
		return a[DW-1] ? DW'(-a) : DW'(a);
	endfunction

	// Equal signs, counting two zeros as equal
	function automatic logic same_sign(cross_t a, cross_t b);
		logic za;
		logic zb;
		za = (a == '0);
		zb = (b == '0);
		return (za && zb) || (a[XW-1] && b[XW-1]) ||
			(!a[XW-1] && !za && !b[XW-1] && !zb);
	endfunction

endpackage

// File: src/si2d_front.sv
// ----------------------------------------------------------------------------
// si2d_front: differences, cross products and rejection tests
// Three stages: coordinate differences, ten 25x25 products, then cross
// products, the side test and the choice of the parameterized segment.
// ----------------------------------------------------------------------------
module si2d_front import si2d_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   mode,
	input  coord_t a1_x,
	input  coord_t a1_z,
	input  coord_t a2_x,
	input  coord_t a2_z,
	input  coord_t b1_x,
	input  coord_t b1_z,
	input  coord_t b2_x,
	input  coord_t b2_z,
	output logic   out_valid,
	output side_t  out_side,
	output cross_t den,
	output cross_t num,
	output diff_t  mul_x,
	output diff_t  mul_z
);

	logic   v_s1, v_s2, v_s3;
	logic   mode_s1, mode_s2;
	logic   deg_a_s1, deg_b_s1, deg_a_s2, deg_b_s2;
	diff_t  dax_s1, daz_s1, dbx_s1, dbz_s1, ex_s1, ez_s1, fx_s1, fz_s1;
	diff_t  dax_s2, daz_s2, dbx_s2, dbz_s2;
	coord_t a1x_s1, a1z_s1, a2x_s1, a2z_s1, b1x_s1, b1z_s1;
	coord_t a1x_s2, a1z_s2, a2x_s2, a2z_s2, b1x_s2, b1z_s2;
	prod_t  s1a_s2, s1b_s2, s2a_s2, s2b_s2, dna_s2, dnb_s2;
	prod_t  nba_s2, nbb_s2, naa_s2, nab_s2;
	logic   sel_a_s2;
	side_t  side_s3;
	cross_t den_s3, num_s3;
	diff_t  mx_s3, mz_s3;
	cross_t c1, c2;
	reason_t rsn;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: differences and degenerate checks
	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		deg_a_s1 <= (a1_x == a2_x) && (a1_z == a2_z);
		deg_b_s1 <= (b1_x == b2_x) && (b1_z == b2_z);
		dax_s1   <= coord_diff(a2_x, a1_x);
		daz_s1   <= coord_diff(a2_z, a1_z);
		dbx_s1   <= coord_diff(b2_x, b1_x);
		dbz_s1   <= coord_diff(b2_z, b1_z);
		ex_s1    <= coord_diff(b1_x, a1_x);
		ez_s1    <= coord_diff(b1_z, a1_z);
		fx_s1    <= coord_diff(b2_x, a1_x);
		fz_s1    <= coord_diff(b2_z, a1_z);
		a1x_s1   <= a1_x;
		a1z_s1   <= a1_z;
		a2x_s1   <= a2_x;
		a2z_s1   <= a2_z;
		b1x_s1   <= b1_x;
		b1z_s1   <= b1_z;
	end

	// Stage 2: products for the side test, denominator and numerators
	always_ff @(posedge clk) begin
		s1a_s2   <= dax_s1 * ez_s1;
		s1b_s2   <= daz_s1 * ex_s1;
		s2a_s2   <= dax_s1 * fz_s1;
		s2b_s2   <= daz_s1 * fx_s1;
		dna_s2   <= dax_s1 * dbz_s1;
		dnb_s2   <= daz_s1 * dbx_s1;
		nba_s2   <= ex_s1 * dbz_s1;
		nbb_s2   <= ez_s1 * dbx_s1;
		naa_s2   <= ex_s1 * daz_s1;
		nab_s2   <= ez_s1 * dax_s1;
		sel_a_s2 <= diff_abs(dbx_s1) < diff_abs(dax_s1);
		mode_s2  <= mode_s1;
		deg_a_s2 <= deg_a_s1;
		deg_b_s2 <= deg_b_s1;
		dax_s2   <= dax_s1;
		daz_s2   <= daz_s1;
		dbx_s2   <= dbx_s1;
		dbz_s2   <= dbz_s1;
		a1x_s2   <= a1x_s1;
		a1z_s2   <= a1z_s1;
		a2x_s2   <= a2x_s1;
		a2z_s2   <= a2z_s1;
		b1x_s2   <= b1x_s1;
		b1z_s2   <= b1z_s1;
	end

	// Side test and early rejection reason
	always_comb begin
		c1 = cross_diff(s1a_s2, s1b_s2);
		c2 = cross_diff(s2a_s2, s2b_s2);
		if (deg_a_s2)
			rsn = REASON_DEG_A;
		else if (deg_b_s2)
			rsn = REASON_DEG_B;
		else if (same_sign(c1, c2))
			rsn = REASON_SAME_SIDE;
		else
			rsn = REASON_HIT;
	end

	// Stage 3: cross products and choice of parameterized segment
	always_ff @(posedge clk) begin
		side_s3.mode   <= mode_s2;
		side_s3.reason <= rsn;
		side_s3.base_x <= sel_a_s2 ? a1x_s2 : b1x_s2;
		side_s3.base_z <= sel_a_s2 ? a1z_s2 : b1z_s2;
		side_s3.a1_x   <= a1x_s2;
		side_s3.a1_z   <= a1z_s2;
		side_s3.a2_x   <= a2x_s2;
		side_s3.a2_z   <= a2z_s2;
		side_s3.b1_x   <= b1x_s2;
		side_s3.b1_z   <= b1z_s2;
		den_s3         <= cross_diff(dna_s2, dnb_s2);
		num_s3         <= sel_a_s2 ? cross_diff(nba_s2, nbb_s2) : cross_diff(naa_s2, nab_s2);
		mx_s3          <= sel_a_s2 ? dax_s2 : dbx_s2;
		mz_s3          <= sel_a_s2 ? daz_s2 : dbz_s2;
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign den       = den_s3;
	assign num       = num_s3;
	assign mul_x     = mx_s3;
	assign mul_z     = mz_s3;

endmodule

// File: src/si2d_div.sv
// ----------------------------------------------------------------------------
// si2d_div: pipelined product and truncating division
// Forms mul*num in two partial products, then divides by den one quotient
// bit per stage. Quotients at or above 2^QBITS in magnitude are clamped,
// which is far enough out to saturate and reject the same as the exact value.
// ----------------------------------------------------------------------------
module si2d_div import si2d_pkg::*; (
	input  logic   clk,
	input  cross_t num,
	input  diff_t  mul,
	input  cross_t den,
	output quot_t  quot
);

	localparam int PLW = DW + LO_W + 1;
	localparam int RW  = XW + QBITS;

	logic signed [PLW-1:0] pl_s1;
	prod_t                 ph_s1;
	cross_t                den_s1, den_s2;
	logic signed [NW-1:0]  n_s2;
	logic [NW-1:0]         nabs_s3, nabs_s4;
	logic [XW-1:0]         dabs_s3, dabs_s4;
	logic                  neg_s3, neg_s4, ovf_s4;
	logic [NW-1:0]         rem_s  [0:QBITS];
	logic [QBITS-1:0]      q_s    [0:QBITS];
	logic [XW-1:0]         dv_s   [0:QBITS];
	logic                  neg_s  [0:QBITS];
	logic                  ovf_s  [0:QBITS];
	quot_t                 quot_q;
	logic [QBITS:0]        mag;

	// Partial products, then sum
	always_ff @(posedge clk) begin
		pl_s1  <= mul * $signed({1'b0, num[LO_W-1:0]});
		ph_s1  <= mul * $signed(num[XW-1:LO_W]);
		den_s1 <= den;
		n_s2   <= (NW'(ph_s1) <<< LO_W) + NW'(pl_s1);
		den_s2 <= den_s1;
	end

	// Magnitudes, result sign, then clamp check
	always_ff @(posedge clk) begin
		nabs_s3 <= n_s2[NW-1] ? NW'(-n_s2) : NW'(n_s2);
		dabs_s3 <= den_s2[XW-1] ? XW'(-den_s2) : XW'(den_s2);
		neg_s3  <= n_s2[NW-1] ^ den_s2[XW-1];
		nabs_s4 <= nabs_s3;
		dabs_s4 <= dabs_s3;
		neg_s4  <= neg_s3;
		ovf_s4  <= RW'(nabs_s3) >= {dabs_s3, QBITS'(0)};
	end

	always_comb begin
		rem_s[0] = nabs_s4;
		q_s[0]   = '0;
		dv_s[0]  = dabs_s4;
		neg_s[0] = neg_s4;
		ovf_s[0] = ovf_s4;
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int B = QBITS - 1 - k;
		logic [RW-1:0] sh;
		logic          ge;
		always_comb begin
			sh = RW'(dv_s[k]) << B;
			ge = RW'(rem_s[k]) >= sh;
		end
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? NW'(RW'(rem_s[k]) - sh) : rem_s[k];
			q_s[k+1]   <= q_s[k] | (QBITS'(ge) << B);
			dv_s[k+1]  <= dv_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	// Apply clamp and sign
	always_comb begin
		mag = ovf_s[QBITS] ? ((QBITS+1)'(1) << QBITS) : {1'b0, q_s[QBITS]};
	end

	always_ff @(posedge clk) begin
		quot_q <= neg_s[QBITS] ? -QW'(mag) : QW'(mag);
	end

	assign quot = quot_q;

endmodule

// File: src/si2d_back.sv
// ----------------------------------------------------------------------------
// si2d_back: point, range test, distance and result register
// Adds the quotient to the base point, tests the point against segment A,
// forms the squared distance to B1 and saturates the outputs.
// ----------------------------------------------------------------------------
module si2d_back import si2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  side_t                 side,
	input  quot_t                 qx,
	input  quot_t                 qz,
	output logic                  done,
	output logic                  hit,
	output logic [2:0]            reason,
	output coord_t                cross_x,
	output coord_t                cross_z,
	output logic [DIST_WIDTH-1:0] dist_squared
);

	localparam logic signed [PXW-1:0] PMAX     = PXW'(2**(CW-1) - 1);
	localparam logic signed [PXW-1:0] PMIN     = -PMAX - PXW'(1);
	localparam logic [PXW-1:0]        FAR_LIM  = PXW'(1) << (CW + 1);
	localparam logic [PXW-1:0]        ROOT_LIM = PXW'(1) << DRW;
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

	logic                       v_s1, v_s2, v_s3, done_q;
	side_t                      side_s1, side_s2, side_s3;
	logic signed [PXW-1:0]      px_s1, pz_s1;
	logic                       far_s2, far_s3, ok_s2, ok_s3;
	logic signed [EW-1:0]       dx1_s2, dx2_s2, dz1_s2, dz2_s2;
	logic [DRW-1:0]             mqx_s2, mqz_s2;
	coord_t                     cx_s2, cz_s2, cx_s3, cz_s3;
	logic signed [2*EW-1:0]     dotx_s3, dotz_s3;
	logic [2*DRW-1:0]           sqx_s3, sqz_s3;
	logic [PXW-1:0]             pxa, pza, qxa, qza;
	logic signed [PXW-1:0]      qxd, qzd;
	coord_t                     cx, cz;
	logic signed [2*EW:0]       dot;
	logic [DIST_WIDTH:0]        dsum;
	logic                       outside;
	logic                       hit_q;
	reason_t                    reason_q;
	coord_t                     cross_x_q, cross_z_q;
	logic [DIST_WIDTH-1:0]      dist_q;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	// Stage 1: point
	always_ff @(posedge clk) begin
		px_s1   <= PXW'(side.base_x) + PXW'(qx);
		pz_s1   <= PXW'(side.base_z) + PXW'(qz);
		side_s1 <= side;
	end

	// Magnitudes, distance offsets and saturation
	always_comb begin
		pxa = px_s1[PXW-1] ? PXW'(-px_s1) : PXW'(px_s1);
		pza = pz_s1[PXW-1] ? PXW'(-pz_s1) : PXW'(pz_s1);
		qxd = px_s1 - PXW'(side_s1.b1_x);
		qzd = pz_s1 - PXW'(side_s1.b1_z);
		qxa = qxd[PXW-1] ? PXW'(-qxd) : PXW'(qxd);
		qza = qzd[PXW-1] ? PXW'(-qzd) : PXW'(qzd);
		if (px_s1 > PMAX)
			cx = CW'(PMAX);
		else if (px_s1 < PMIN)
			cx = CW'(PMIN);
		else
			cx = CW'(px_s1);
		if (pz_s1 > PMAX)
			cz = CW'(PMAX);
		else if (pz_s1 < PMIN)
			cz = CW'(PMIN);
		else
			cz = CW'(pz_s1);
	end

	// Stage 2: offsets from the ends of A and from B1
	always_ff @(posedge clk) begin
		far_s2  <= (pxa >= FAR_LIM) || (pza >= FAR_LIM);
		ok_s2   <= (qxa < ROOT_LIM) && (qza < ROOT_LIM);
		dx1_s2  <= EW'(px_s1 - PXW'(side_s1.a1_x));
		dx2_s2  <= EW'(px_s1 - PXW'(side_s1.a2_x));
		dz1_s2  <= EW'(pz_s1 - PXW'(side_s1.a1_z));
		dz2_s2  <= EW'(pz_s1 - PXW'(side_s1.a2_z));
		mqx_s2  <= DRW'(qxa);
		mqz_s2  <= DRW'(qza);
		cx_s2   <= cx;
		cz_s2   <= cz;
		side_s2 <= side_s1;
	end

	// Stage 3: dot product terms and squares
	always_ff @(posedge clk) begin
		dotx_s3 <= dx1_s2 * dx2_s2;
		dotz_s3 <= dz1_s2 * dz2_s2;
		sqx_s3  <= mqx_s2 * mqx_s2;
		sqz_s3  <= mqz_s2 * mqz_s2;
		far_s3  <= far_s2;
		ok_s3   <= ok_s2;
		cx_s3   <= cx_s2;
		cz_s3   <= cz_s2;
		side_s3 <= side_s2;
	end

	always_comb begin
		dot     = (2*EW+1)'(dotx_s3) + (2*EW+1)'(dotz_s3);
		dsum    = (DIST_WIDTH+1)'(sqx_s3) + (DIST_WIDTH+1)'(sqz_s3);
		outside = !side_s3.mode && (far_s3 || (!dot[2*EW] && (dot != '0)));
	end

	// Stage 4: result register
	always_ff @(posedge clk) begin
		if (side_s3.reason != REASON_HIT || outside) begin
			hit_q     <= 1'b0;
			reason_q  <= (side_s3.reason != REASON_HIT) ? side_s3.reason : REASON_OUTSIDE;
			cross_x_q <= '0;
			cross_z_q <= '0;
			dist_q    <= '0;
		end else begin
			hit_q     <= 1'b1;
			reason_q  <= REASON_HIT;
			cross_x_q <= cx_s3;
			cross_z_q <= cz_s3;
			if (!ok_s3 || dsum > (DIST_WIDTH+1)'(DIST_MAX))
				dist_q <= DIST_MAX;
			else
				dist_q <= DIST_WIDTH'(dsum);
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign reason       = reason_q;
	assign cross_x      = cross_x_q;
	assign cross_z      = cross_z_q;
	assign dist_squared = dist_q;

endmodule

// File: src/segment_intersection_2d_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d_top: 2D segment intersection engine
// Tests segment B against segment or line A and returns the crossing point
// and its squared distance to the start of B, in Q15.8 fixed point.
//
//   channel   signals                                   direction
//   request   start, busy, mode, a_*, b_*               in
//   result    done, hit, reason, cross_x/z, dist_squared out
//
// One request is taken per cycle; busy is never raised.
// Each result passes 3 front stages, 32 divider stages (4 to form and size
// the dividend, 27 with one quotient bit each and 1 to apply the sign), then
// 4 back stages, and is shown for one cycle.
// Reset clears all valid bits; no data path register is reset.
// The result side cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module segment_intersection_2d_top import si2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  coord_t                a_start_x,
	input  coord_t                a_start_z,
	input  coord_t                a_end_x,
	input  coord_t                a_end_z,
	input  coord_t                b_start_x,
	input  coord_t                b_start_z,
	input  coord_t                b_end_x,
	input  coord_t                b_end_z,
	output logic                  done,
	output logic                  hit,
	output logic [2:0]            reason,
	output coord_t                cross_x,
	output coord_t                cross_z,
	output logic [DIST_WIDTH-1:0] dist_squared
);

	logic   f_valid;
	side_t  f_side;
	cross_t f_den, f_num;
	diff_t  f_mul_x, f_mul_z;
	quot_t  qx, qz;
	logic   dly_valid_q [0:DIV_LAT-1];
	side_t  dly_side_q  [0:DIV_LAT-1];

	assign busy = 1'b0;

	si2d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.mode      (mode),
		.a1_x      (a_start_x),
		.a1_z      (a_start_z),
		.a2_x      (a_end_x),
		.a2_z      (a_end_z),
		.b1_x      (b_start_x),
		.b1_z      (b_start_z),
		.b2_x      (b_end_x),
		.b2_z      (b_end_z),
		.out_valid (f_valid),
		.out_side  (f_side),
		.den       (f_den),
		.num       (f_num),
		.mul_x     (f_mul_x),
		.mul_z     (f_mul_z)
	);

	si2d_div u_div_x (
		.clk  (clk),
		.num  (f_num),
		.mul  (f_mul_x),
		.den  (f_den),
		.quot (qx)
	);

	si2d_div u_div_z (
		.clk  (clk),
		.num  (f_num),
		.mul  (f_mul_z),
		.den  (f_den),
		.quot (qz)
	);

	// Carry valid bits beside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				dly_valid_q[i] <= 1'b0;
		end else begin
			dly_valid_q[0] <= f_valid;
			for (int i = 1; i < DIV_LAT; i++)
				dly_valid_q[i] <= dly_valid_q[i-1];
		end
	end

	// Carry request data beside the dividers
	always_ff @(posedge clk) begin
		dly_side_q[0] <= f_side;
		for (int i = 1; i < DIV_LAT; i++)
			dly_side_q[i] <= dly_side_q[i-1];
	end

	si2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (dly_valid_q[DIV_LAT-1]),
		.side         (dly_side_q[DIV_LAT-1]),
		.qx           (qx),
		.qz           (qz),
		.done         (done),
		.hit          (hit),
		.reason       (reason),
		.cross_x      (cross_x),
		.cross_z      (cross_z),
		.dist_squared (dist_squared)
	);

endmodule

// File: src/si2d_checker.sv
// ----------------------------------------------------------------------------
// si2d_checker: port-level checks
// Watches the request and result ports of the top level for latency and
// result consistency.
// ----------------------------------------------------------------------------
module si2d_checker import si2d_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  hit,
	input logic [2:0]            reason,
	input coord_t                cross_x,
	input coord_t                cross_z,
	input logic [DIST_WIDTH-1:0] dist_squared
);

	// Every accepted request gets its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request without result at expected latency");

	// Hit flag agrees with the reason code
	a_hit_reason: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit == (reason == REASON_HIT)))
		else $error("hit flag and reason disagree");

	// A miss carries a zero point and distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (cross_x == '0 && cross_z == '0 && dist_squared == '0))
		else $error("miss with nonzero payload");

endmodule

bind segment_intersection_2d_top si2d_checker u_si2d_checker (.*);

// File: bench/segment_intersection_2d_top_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_2d_top_tb: self-checking bench for the 2D segment
// intersection engine
// Drives directed and random segment pairs with random gaps. An exact-integer
// model predicts hit, reason, crossing point and squared distance for each
// request. Each strobed result is compared in order against those predictions.
// ----------------------------------------------------------------------------
module segment_intersection_2d_top_tb;
	import si2d_pkg::*;

	localparam int N_RANDOM = 930;
	localparam int WDOG_LIMIT = 2000;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic   mode;
		coord_t a1x, a1z, a2x, a2z, b1x, b1z, b2x, b2z;
	} seg_pair_t;

	typedef struct {
		logic                  hit;
		reason_t               reason;
		coord_t                px;
		coord_t                pz;
		logic [DIST_WIDTH-1:0] dist_sq;
	} crossing_t;

	// Predicts crossings and holds those still due from the engine
	class crossing_board;
		crossing_t pending[$];
		int        errors;
		int        seen[5];

		static function int sgn(wide_t v);
			return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
		endfunction

		static function wide_t mag(wide_t v);
			return (v < 0) ? -v : v;
		endfunction

		static function coord_t clamp_coord(wide_t v);
			if (v > wide_t'(2 ** (CW - 1) - 1))
				return coord_t'(2 ** (CW - 1) - 1);
			if (v < -wide_t'(2 ** (CW - 1)))
				return coord_t'(-(2 ** (CW - 1)));
			return coord_t'(v);
		endfunction

		static function crossing_t predict(seg_pair_t s);
			crossing_t r;
			wide_t a1x, a1z, a2x, a2z, b1x, b1z, b2x, b2z;
			wide_t dax, daz, dbx, dbz, ex, ez, den, num, px, pz, qx, qz, dot, d;
			wide_t far, root, dmax;
			a1x = s.a1x; a1z = s.a1z; a2x = s.a2x; a2z = s.a2z;
			b1x = s.b1x; b1z = s.b1z; b2x = s.b2x; b2z = s.b2z;
			dax = a2x - a1x; daz = a2z - a1z;
			dbx = b2x - b1x; dbz = b2z - b1z;
			ex = b1x - a1x; ez = b1z - a1z;
			far = wide_t'(1) <<< (CW + 1);
			root = wide_t'(1) <<< DRW;
			dmax = (wide_t'(1) <<< DIST_WIDTH) - 1;
			r = '{hit: 1'b0, reason: REASON_HIT, px: '0, pz: '0, dist_sq: '0};
			if (dax == 0 && daz == 0) begin
				r.reason = REASON_DEG_A;
				return r;
			end
			if (dbx == 0 && dbz == 0) begin
				r.reason = REASON_DEG_B;
				return r;
			end
			if (sgn(dax * ez - daz * ex) ==
					sgn(dax * (b2z - a1z) - daz * (b2x - a1x))) begin
				r.reason = REASON_SAME_SIDE;
				return r;
			end
			den = dax * dbz - daz * dbx;
			// parameterize on the segment with the wider x extent
			if (mag(dax) > mag(dbx)) begin
				num = ex * dbz - ez * dbx;
				px = a1x + ((den == 0) ? 0 : (dax * num) / den);
				pz = a1z + ((den == 0) ? 0 : (daz * num) / den);
			end else begin
				num = ex * daz - ez * dax;
				px = b1x + ((den == 0) ? 0 : (dbx * num) / den);
				pz = b1z + ((den == 0) ? 0 : (dbz * num) / den);
			end
			if (!s.mode) begin
				if (mag(px) >= far || mag(pz) >= far) begin
					r.reason = REASON_OUTSIDE;
					return r;
				end
				dot = (px - a1x) * (px - a2x) + (pz - a1z) * (pz - a2z);
				if (dot > 0) begin
					r.reason = REASON_OUTSIDE;
					return r;
				end
			end
			r.hit = 1'b1;
			r.px = clamp_coord(px);
			r.pz = clamp_coord(pz);
			qx = mag(px - b1x);
			qz = mag(pz - b1z);
			if (qx < root && qz < root) begin
				d = qx * qx + qz * qz;
				r.dist_sq = (d > dmax) ? dmax[DIST_WIDTH-1:0] : d[DIST_WIDTH-1:0];
			end else begin
				r.dist_sq = dmax[DIST_WIDTH-1:0];
			end
			return r;
		endfunction

		function void note_request(seg_pair_t s);
			pending.push_back(predict(s));
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(crossing_t got);
			crossing_t want;
			if (pending.size() == 0) begin
				$display("mismatch: result with no request outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			seen[want.reason]++;
			if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
			if (got.reason !== want.reason) report_mismatch("reason", got.reason, want.reason);
			if (got.px !== want.px) report_mismatch("cross_x", got.px, want.px);
			if (got.pz !== want.pz) report_mismatch("cross_z", got.pz, want.pz);
			if (got.dist_sq !== want.dist_sq)
				report_mismatch("dist_squared", got.dist_sq, want.dist_sq);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  mode = 1'b0;
	coord_t                a_start_x = '0, a_start_z = '0, a_end_x = '0, a_end_z = '0;
	coord_t                b_start_x = '0, b_start_z = '0, b_end_x = '0, b_end_z = '0;
	logic                  done;
	logic                  hit;
	logic [2:0]            reason;
	coord_t                cross_x, cross_z;
	logic [DIST_WIDTH-1:0] dist_squared;

	crossing_board sb = new();
	int            idle_cycles = 0;
	int            n_sent = 0;

	segment_intersection_2d_top u_top (.*);

	always #5 clk = ~clk;

	// note accepted requests, check strobed results, watch for a stall
	always @(posedge clk) begin
		seg_pair_t s;
		if (arst_n) begin
			if (start && !busy) begin
				s = '{mode, a_start_x, a_start_z, a_end_x, a_end_z,
					b_start_x, b_start_z, b_end_x, b_end_z};
				sb.note_request(s);
			end
			if (done)
				sb.check_result('{hit, reason_t'(reason), cross_x, cross_z, dist_squared});
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long, many back to back
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send(seg_pair_t s, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= s.mode;
		a_start_x <= s.a1x; a_start_z <= s.a1z; a_end_x <= s.a2x; a_end_z <= s.a2z;
		b_start_x <= s.b1x; b_start_z <= s.b1z; b_end_x <= s.b2x; b_end_z <= s.b2z;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic send_pts(logic m, int ax1, int az1, int ax2, int az2,
			int bx1, int bz1, int bx2, int bz2);
		seg_pair_t s;
		s = '{m, coord_t'(ax1), coord_t'(az1), coord_t'(ax2), coord_t'(az2),
			coord_t'(bx1), coord_t'(bz1), coord_t'(bx2), coord_t'(bz2)};
		send(s, pick_gap());
	endtask

	function automatic coord_t rand_coord(int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
			2: return coord_t'($urandom_range(0, 8192)) - coord_t'(4096);
			default: return ($urandom_range(0, 1) != 0) ? coord_t'(2 ** (CW - 1) - 1)
				: coord_t'(-(2 ** (CW - 1)));
		endcase
	endfunction

	initial begin
		int        k;
		int        kind;
		int        lim;
		seg_pair_t s;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain crossing in both modes
		send_pts(0, -512, 0, 512, 0, 0, -512, 0, 512);
		send_pts(1, -512, 0, 512, 0, 0, -512, 0, 512);
		// degenerate A, degenerate B, both degenerate
		send_pts(0, 100, 100, 100, 100, 0, -5, 0, 5);
		send_pts(0, -5, 0, 5, 0, 77, 77, 77, 77);
		send_pts(1, 3, 3, 3, 3, 3, 3, 3, 3);
		// same side, both ends on line A, parallel
		send_pts(0, 0, 0, 256, 0, 10, 5, 20, 9);
		send_pts(0, 0, 0, 256, 0, -10, 0, 300, 0);
		send_pts(1, 0, 0, 256, 256, 0, 10, 256, 266);
		// one end of B touching line A
		send_pts(0, 0, 0, 256, 0, 128, 0, 128, 64);
		// point beyond A: rejected in segment mode, kept in line mode
		send_pts(0, 0, 0, 10, 0, 500, -5, 500, 5);
		send_pts(1, 0, 0, 10, 0, 500, -5, 500, 5);
		// extremes of the coordinate range
		send_pts(0, -8388608, -8388608, 8388607, 8388607,
			-8388608, 8388607, 8388607, -8388608);
		send_pts(1, 8388607, -8388608, -8388608, 8388607,
			8388607, 8388607, -8388608, -8388608);
		send_pts(1, -8388608, 0, 8388607, 0, 0, -8388608, 0, 8388607);
		// near-parallel lines: far point, saturated output and distance
		send_pts(1, 0, 0, 8388607, 1, -8388608, -1, 8388607, 1);
		send_pts(1, 0, 0, 1, 8388607, -1, -8388608, 2, 8388607);
		send_pts(0, 0, 0, 8388607, 1, -8388608, -1, 8388607, 1);
		// steep segments with tiny x extents, both parameterizations
		send_pts(0, 0, -1000, 1, 1000, -1000, 0, 1000, 3);
		send_pts(0, -1000, 0, 1000, 3, 0, -1000, 1, 1000);
		send_pts(1, -1, -7, 2, 9, 5, -3, -6, 4);

		// random: mostly small coordinates so crossings are common
		for (k = 0; k < N_RANDOM; k++) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 2) ? 0 : (kind < 6) ? 1 : (kind < 9) ? 2 : 3;
			s.mode = $urandom_range(0, 1);
			s.a1x = rand_coord(kind); s.a1z = rand_coord(kind);
			s.a2x = rand_coord(kind); s.a2z = rand_coord(kind);
			s.b1x = rand_coord(kind); s.b1z = rand_coord(kind);
			s.b2x = rand_coord(kind); s.b2z = rand_coord(kind);
			// push B ends to opposite sides of A most of the time
			if ($urandom_range(0, 3) != 0) begin
				s.b2x = s.a1x + s.a2x - s.b1x;
				s.b2z = s.a1z + s.a2z - s.b1z;
				s.b2x = s.b2x + coord_t'($urandom_range(0, 4)) - coord_t'(2);
			end
			send(s, pick_gap());
		end
		start <= 1'b0;

		// drain
		lim = 0;
		while (sb.pending.size() != 0 && lim < 10 * LATENCY) begin
			@(posedge clk);
			lim++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0d results never arrived", sb.pending.size());
			sb.errors += sb.pending.size();
		end

		$display("ran %0d requests: %0d hits, %0d degenerate A, %0d degenerate B,",
			n_sent, sb.seen[0], sb.seen[1], sb.seen[2]);
		$display("  %0d same side, %0d outside A; %0d mismatches",
			sb.seen[3], sb.seen[4], sb.errors);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
